// ===== hw/rtl/modular_exponentiation_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Modular exponentiation unit assertion macros
// Shared assertion forms for the checker; clk and rst_n come from the scope.
// ----------------------------------------------------------------------------
`ifndef MODULAR_EXPONENTIATION_UNIT_DEFINES_SVH
`define MODULAR_EXPONENTIATION_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MEU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define MEU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/meu_pkg.sv =====
// ----------------------------------------------------------------------------
// Modular exponentiation unit package
// Field widths, modulus reset value and sequencer state type.
// ----------------------------------------------------------------------------
package meu_pkg;

  localparam int IN_W      = 63;                 // base and exponent width
  localparam int MOD_W     = 32;                 // modulus and residue width
  localparam int CFG_W     = 32;                 // configuration data width
  localparam int OUT_W     = 32;                 // power width
  localparam int EXT_W     = MOD_W + 2;          // room for 2*acc + operand
  localparam int CNT_W     = $clog2(IN_W + 1);   // step counter width

  localparam logic [MOD_W-1:0] MOD_RESET = MOD_W'(32'd1000000007);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_MUL,
    ST_SQR
  } meu_state_t;

endpackage

// ===== hw/rtl/modular_exponentiation_unit.sv =====
// ----------------------------------------------------------------------------
// Modular exponentiation unit
// Right-to-left binary square and multiply, base^exponent mod modulus.
// ----------------------------------------------------------------------------
//
//  channel  | ports                         | handshake
//  ---------+-------------------------------+-----------------------------------
//  request  | in_base, in_exponent          | start, taken when busy is low
//  result   | out_power                     | out_valid, one cycle, no backpressure
//  config   | cfg_modulus                   | cfg_we, write while idle
//
//  One shared shift-add-reduce step unit does all arithmetic, one bit a cycle.
//  A request first reduces the base, then runs one modular multiply per set
//  exponent bit plus one square per bit below the top set bit, at most 125 in
//  all, and then registers the result.
//  A zero exponent returns 1 on the next cycle without going busy.
//  Reset (synchronous, rst_n low) idles the sequencer and reloads the modulus.
//  The result is a one-cycle strobe; the receiver cannot stall it.
// ----------------------------------------------------------------------------
module modular_exponentiation_unit
  import meu_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [IN_W-1:0]  in_base,
  input  logic [IN_W-1:0]  in_exponent,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_modulus,
  output logic             out_valid,
  output logic [OUT_W-1:0] out_power
);

  // Sequencer
  meu_state_t       state_r, state_nxt;

  // Configuration
  logic [MOD_W-1:0] modulus_r;

  // Shared step unit registers: accumulator, addend and multiplier bit stream
  logic [MOD_W-1:0] acc_r, acc_nxt;
  logic [MOD_W-1:0] opnd_r, opnd_nxt;
  logic [IN_W-1:0]  mbits_r, mbits_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // Exponentiation state
  logic [IN_W-1:0]  exp_r, exp_nxt;
  logic [MOD_W-1:0] prod_r, prod_nxt;
  logic [MOD_W-1:0] sq_r, sq_nxt;

  // Result register
  logic             out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0] out_power_r, out_power_nxt;

  // Step unit datapath
  logic [EXT_W-1:0] m_ext;
  logic [EXT_W-1:0] twice_m;
  logic [EXT_W-1:0] sum;
  logic [EXT_W-1:0] step_ext;
  logic [MOD_W-1:0] step_res;
  logic             last_step;
  logic             accept;
  logic [MOD_W-1:0] sq_src;
  logic             exp_upper_zero;

  assign accept = start && (state_r == ST_IDLE);

  // --------------------------------------------------------------------------
  // Step unit: acc <- (2*acc + bit*opnd) mod m. The sum stays below 3m, so
  // compare against m and 2m side by side and take one subtraction.
  // A zero modulus register means 2^MOD_W, which the extra top bit carries.
  // --------------------------------------------------------------------------
  always_comb begin
    m_ext   = {1'b0, (modulus_r == '0), modulus_r};
    twice_m = {m_ext[EXT_W-2:0], 1'b0};
    sum     = {1'b0, acc_r, 1'b0} + (mbits_r[IN_W-1] ? {2'b00, opnd_r} : '0);
    if (sum >= twice_m) begin
      step_ext = sum - twice_m;
    end else if (sum >= m_ext) begin
      step_ext = sum - m_ext;
    end else begin
      step_ext = sum;
    end
    step_res  = step_ext[MOD_W-1:0];
    last_step = (cnt_r == CNT_W'(1));
  end

  // Residue feeding the next square or multiply: a just-finished square or
  // reduction overrides the stored squared base.
  assign sq_src         = (state_r == ST_MUL) ? sq_r : step_res;
  assign exp_upper_zero = (exp_r[IN_W-1:1] == '0);

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && (in_exponent != '0)) begin
          state_nxt = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (last_step) begin
          state_nxt = exp_r[0] ? ST_MUL : ST_SQR;
        end
      end
      ST_MUL: begin
        if (last_step) begin
          state_nxt = exp_upper_zero ? ST_IDLE : ST_SQR;
        end
      end
      ST_SQR: begin
        // exp_r[1] is the low bit of the exponent once this square retires
        if (last_step) begin
          state_nxt = exp_r[1] ? ST_MUL : ST_SQR;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Datapath next values
  // --------------------------------------------------------------------------
  always_comb begin
    acc_nxt       = acc_r;
    opnd_nxt      = opnd_r;
    mbits_nxt     = mbits_r;
    cnt_nxt       = cnt_r;
    exp_nxt       = exp_r;
    prod_nxt      = prod_r;
    sq_nxt        = sq_r;
    out_valid_nxt = 1'b0;
    out_power_nxt = out_power_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_exponent == '0) begin
            // Zero exponent: answer 1 at once, for any modulus
            out_valid_nxt = 1'b1;
            out_power_nxt = OUT_W'(1);
          end else begin
            // Load base reduction: shift base bits in with addend 1
            acc_nxt   = '0;
            opnd_nxt  = MOD_W'(1);
            mbits_nxt = in_base;
            cnt_nxt   = CNT_W'(IN_W);
            exp_nxt   = in_exponent;
            prod_nxt  = MOD_W'(1);
          end
        end
      end
      ST_REDUCE, ST_MUL, ST_SQR: begin
        // Advance the shared unit one multiplier bit
        acc_nxt   = step_res;
        mbits_nxt = {mbits_r[IN_W-2:0], 1'b0};
        cnt_nxt   = cnt_r - CNT_W'(1);
        if (last_step) begin
          if (state_r == ST_MUL) begin
            prod_nxt = step_res;
          end else begin
            sq_nxt = step_res;
          end
          if (state_r == ST_SQR) begin
            exp_nxt = {1'b0, exp_r[IN_W-1:1]};
          end
          // Reload the unit for the next multiply or square
          acc_nxt = '0;
          cnt_nxt = CNT_W'(MOD_W);
          if (state_nxt == ST_MUL) begin
            mbits_nxt = {prod_r, {(IN_W-MOD_W){1'b0}}};
            opnd_nxt  = sq_src;
          end else begin
            mbits_nxt = {sq_src, {(IN_W-MOD_W){1'b0}}};
            opnd_nxt  = sq_src;
          end
          if (state_nxt == ST_IDLE) begin
            out_valid_nxt = 1'b1;
            out_power_nxt = OUT_W'(step_res);
          end
        end
      end
      default: begin
        acc_nxt = '0;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Outputs
  // --------------------------------------------------------------------------
  always_comb begin
    busy      = (state_r != ST_IDLE);
    out_valid = out_valid_r;
    out_power = out_power_r;
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      modulus_r   <= MOD_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        modulus_r <= cfg_modulus[MOD_W-1:0];
      end
    end
  end

  // Payload: no reset needed
  always_ff @(posedge clk) begin
    acc_r       <= acc_nxt;
    opnd_r      <= opnd_nxt;
    mbits_r     <= mbits_nxt;
    cnt_r       <= cnt_nxt;
    exp_r       <= exp_nxt;
    prod_r      <= prod_nxt;
    sq_r        <= sq_nxt;
    out_power_r <= out_power_nxt;
  end

endmodule

// ===== hw/rtl/meu_checker.sv =====
// ----------------------------------------------------------------------------
// Modular exponentiation unit checker
// Port-level timing checks on requests and results, bound to the top level.
// ----------------------------------------------------------------------------
`include "modular_exponentiation_unit_defines.svh"

module meu_checker
  import meu_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             start,
  input logic             busy,
  input logic [IN_W-1:0]  in_exponent,
  input logic             out_valid,
  input logic [OUT_W-1:0] out_power
);

  // A request with a nonzero exponent makes the unit go busy
  `MEU_ASSERT_NEXT(a_nonzero_goes_busy, start && !busy && (in_exponent != '0), busy, "request not started")

  // A zero exponent answers 1 on the very next cycle
  `MEU_ASSERT_NEXT(a_zero_exp_one, start && !busy && (in_exponent == '0), out_valid && (out_power == OUT_W'(1)) && !busy, "zero exponent result wrong")

  // A result only shows once the sequencer is back to idle
  `MEU_ASSERT_NOW(a_result_when_idle, out_valid, !busy, "result while busy")

  // Finishing a request always strobes a result
  `MEU_ASSERT_NOW(a_done_strobes, $fell(busy) && $past(rst_n), out_valid, "request finished without result")

endmodule

bind modular_exponentiation_unit meu_checker u_meu_checker (.*);
